// ----- rtl/mbr_pkg.sv -----
package mbr_pkg;

    localparam int unsigned OP_W    = 5;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned GPR_W   = 64;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned DMA_W   = 10;

    localparam logic [OP_W-1:0] OP_J      = 5'd0;
    localparam logic [OP_W-1:0] OP_JAL    = 5'd1;
    localparam logic [OP_W-1:0] OP_JR     = 5'd2;
    localparam logic [OP_W-1:0] OP_JALR   = 5'd3;
    localparam logic [OP_W-1:0] OP_BEQ    = 5'd4;
    localparam logic [OP_W-1:0] OP_BNE    = 5'd5;
    localparam logic [OP_W-1:0] OP_BLTZ   = 5'd6;
    localparam logic [OP_W-1:0] OP_BGEZ   = 5'd7;
    localparam logic [OP_W-1:0] OP_BLEZ   = 5'd8;
    localparam logic [OP_W-1:0] OP_BGTZ   = 5'd9;
    localparam logic [OP_W-1:0] OP_BLTZAL = 5'd10;
    localparam logic [OP_W-1:0] OP_BGEZAL = 5'd11;
    localparam logic [OP_W-1:0] OP_BC1F   = 5'd12;
    localparam logic [OP_W-1:0] OP_BC1T   = 5'd13;
    localparam logic [OP_W-1:0] OP_BC2F   = 5'd14;
    localparam logic [OP_W-1:0] OP_BC2T   = 5'd15;
    localparam logic [OP_W-1:0] OP_BC0F   = 5'd16;
    localparam logic [OP_W-1:0] OP_BC0T   = 5'd17;
    localparam logic [OP_W-1:0] OP_BEQL   = 5'd18;
    localparam logic [OP_W-1:0] OP_BGTZL  = 5'd23;
    localparam logic [OP_W-1:0] OP_BC0TL  = 5'd29;

    localparam logic [OP_W-1:0] LIKELY_GPR_OFS = OP_BEQL - OP_BEQ;
    localparam logic [OP_W-1:0] LIKELY_COP_OFS = 5'd12;

    localparam logic [REG_W-1:0] LINK_REG = 5'd31;

    localparam logic [DMA_W-1:0] DMA_MASK   = 10'h3FF;
    localparam int unsigned      FPU_C_POS  = 23;
    localparam int unsigned      VPU_C_POS  = 8;

    typedef struct packed {
        logic [ADDR_W-1:0] next_pc;
        logic              taken;
        logic              link_write;
        logic [REG_W-1:0]  link_register;
        logic [ADDR_W-1:0] link_value;
        logic              nullify_delay;
    } t_result;

endpackage

// ----- rtl/mips_branch_resolve.sv -----
// Branch and jump resolution for an R5900-style core. Each request carries the
// branch kind, the rs/rt values, the precomputed target, fallthrough and link
// addresses and the coprocessor condition words; the block returns the next PC,
// the taken flag, the link write and the likely-form delay-slot nullify flag.
// Requests are registered on entry and the result is registered on exit; one
// request per cycle is sustained while the result side does not stall. A stall
// on the result side holds the result register and, once the input register is
// full as well, stalls the request side. Undefined kinds pass the fallthrough
// address with all flags clear.
module mips_branch_resolve (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mbr_pkg::OP_W-1:0]      i_operation,
    input  logic [mbr_pkg::REG_W-1:0]     i_rs_index,
    input  logic signed [mbr_pkg::GPR_W-1:0] i_rs_value,
    input  logic signed [mbr_pkg::GPR_W-1:0] i_rt_value,
    input  logic [mbr_pkg::REG_W-1:0]     i_rd_index,
    input  logic [mbr_pkg::ADDR_W-1:0]    i_target_pc,
    input  logic [mbr_pkg::ADDR_W-1:0]    i_fallthrough_pc,
    input  logic [mbr_pkg::ADDR_W-1:0]    i_link_pc,
    input  logic [mbr_pkg::WORD_W-1:0]    i_fpu_control,
    input  logic [mbr_pkg::WORD_W-1:0]    i_vpu_stat,
    input  logic [mbr_pkg::DMA_W-1:0]     i_dma_stat_cis,
    input  logic [mbr_pkg::DMA_W-1:0]     i_dma_pcr_cpc,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mbr_pkg::ADDR_W-1:0]    o_next_pc,
    output logic                          o_taken,
    output logic                          o_link_write,
    output logic [mbr_pkg::REG_W-1:0]     o_link_register,
    output logic [mbr_pkg::ADDR_W-1:0]    o_link_value,
    output logic                          o_nullify_delay
);
    import mbr_pkg::*;

    logic                r_in_valid;
    logic [OP_W-1:0]     r_op;
    logic [REG_W-1:0]    r_rs_idx;
    logic [GPR_W-1:0]    r_rs;
    logic [GPR_W-1:0]    r_rt;
    logic [REG_W-1:0]    r_rd;
    logic [ADDR_W-1:0]   r_target;
    logic [ADDR_W-1:0]   r_fall;
    logic [ADDR_W-1:0]   r_link;
    logic                r_c1;
    logic                r_c2;
    logic                r_c0;

    logic                r_out_valid;
    t_result             r_res;
    t_result             n_res;

    logic                out_move;
    logic                in_move;

    logic [OP_W-1:0]     base;
    logic                likely;
    logic                al_form;
    logic [GPR_W-1:0]    cmp_rs;
    logic                neg;
    logic                zero;
    logic                tk;
    logic                lw;
    logic [REG_W-1:0]    lreg;

    assign out_move = !r_out_valid || !i_stall;
    assign in_move  = !r_in_valid || out_move;
    assign o_stall  = !in_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_move) begin
            r_in_valid <= i_valid;
        end
        if (in_move && i_valid) begin
            r_op     <= i_operation;
            r_rs_idx <= i_rs_index;
            r_rs     <= i_rs_value;
            r_rt     <= i_rt_value;
            r_rd     <= i_rd_index;
            r_target <= i_target_pc;
            r_fall   <= i_fallthrough_pc;
            r_link   <= i_link_pc;
            r_c1     <= i_fpu_control[FPU_C_POS];
            r_c2     <= i_vpu_stat[VPU_C_POS];
            r_c0     <= ((i_dma_stat_cis | ~i_dma_pcr_cpc) & DMA_MASK) == DMA_MASK;
        end
    end

    always_comb begin
        likely = (r_op >= OP_BEQL) && (r_op <= OP_BC0TL);
        if (!likely) begin
            base = r_op;
        end else if (r_op <= OP_BGTZL) begin
            base = r_op - LIKELY_GPR_OFS;
        end else begin
            base = r_op - LIKELY_COP_OFS;
        end

        al_form = (base == OP_BLTZAL) || (base == OP_BGEZAL);
        cmp_rs  = (al_form && r_rs_idx == LINK_REG) ? {{(GPR_W-ADDR_W){1'b0}}, r_link} : r_rs;
        neg     = cmp_rs[GPR_W-1];
        zero    = cmp_rs == '0;

        tk   = 1'b0;
        lw   = al_form;
        lreg = al_form ? LINK_REG : '0;
        unique case (base)
            OP_J:      tk = 1'b1;
            OP_JAL: begin
                tk   = 1'b1;
                lw   = 1'b1;
                lreg = LINK_REG;
            end
            OP_JR:     tk = 1'b1;
            OP_JALR: begin
                tk = 1'b1;
                if (r_rd != '0) begin
                    lw   = 1'b1;
                    lreg = r_rd;
                end
            end
            OP_BEQ:    tk = cmp_rs == r_rt;
            OP_BNE:    tk = cmp_rs != r_rt;
            OP_BLTZ, OP_BLTZAL: tk = neg;
            OP_BGEZ, OP_BGEZAL: tk = !neg;
            OP_BLEZ:   tk = neg || zero;
            OP_BGTZ:   tk = !neg && !zero;
            OP_BC1F:   tk = !r_c1;
            OP_BC1T:   tk = r_c1;
            OP_BC2F:   tk = !r_c2;
            OP_BC2T:   tk = r_c2;
            OP_BC0F:   tk = !r_c0;
            OP_BC0T:   tk = r_c0;
            default:   tk = 1'b0;
        endcase

        priority if (base == OP_JR || base == OP_JALR) begin
            n_res.next_pc = r_rs[ADDR_W-1:0];
        end else if (tk) begin
            n_res.next_pc = r_target;
        end else begin
            n_res.next_pc = r_fall;
        end
        n_res.taken         = tk;
        n_res.link_write    = lw;
        n_res.link_register = lw ? lreg : '0;
        n_res.link_value    = lw ? r_link : '0;
        n_res.nullify_delay = likely && !tk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_move) begin
            r_out_valid <= r_in_valid;
        end
        if (out_move && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_next_pc       = r_res.next_pc;
    assign o_taken         = r_res.taken;
    assign o_link_write    = r_res.link_write;
    assign o_link_register = r_res.link_register;
    assign o_link_value    = r_res.link_value;
    assign o_nullify_delay = r_res.nullify_delay;

    a_null_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_nullify_delay |-> !o_taken)
        else $error("nullify with taken branch");

    a_no_link_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_link_write |-> o_link_register == '0 && o_link_value == '0)
        else $error("link fields set without link write");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("stall without pending work");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_move && !r_in_valid |=> !o_valid)
        else $error("result appeared without request");

endmodule
